[hdl/hilbert_index_codec_top_macros.svh]
// Assertion macros for the Hilbert index codec.
// No dependencies; included by hilbert_index_codec_top, which checks its own logic.
`ifndef HILBERT_INDEX_CODEC_TOP_MACROS_SVH
`define HILBERT_INDEX_CODEC_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HIC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define HIC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/hic_pkg.sv]
// Types, constants and bit-level functions of the Hilbert index codec.
// No dependencies; imported by hilbert_index_codec_top.
`timescale 1ns / 1ps
package hic_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned CoordIdxW  = $clog2(COORD_BITS);
  localparam int unsigned KeyW       = 3 * COORD_BITS;
  localparam int unsigned InDataW    = 3 * COORD_BITS + KeyW;
  localparam int unsigned OutDataW   = KeyW + 3 * COORD_BITS;
  localparam int unsigned DimsW      = 2;
  localparam logic [DimsW-1:0] DimsReset = 2'd2;
  localparam logic [DimsW-1:0] Dims3D    = 2'd3;

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [2:0][COORD_BITS-1:0] ax_t;
  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    action_e act;
    logic    n3;
    ax_t     ax;
  } stage_t;

  // One bit level of the transpose loop; decode walks the axes in reverse.
  function automatic ax_t hic_step(ax_t ax, action_e act, logic n3,
                                   logic [CoordIdxW-1:0] qb);
    ax_t        r;
    coord_t     p;
    coord_t     t;
    logic [1:0] i;
    r = ax;
    p = coord_t'((32'd1 << qb) - 32'd1);
    for (int unsigned idx = 0; idx < 3; idx++) begin
      if (idx < (n3 ? 3 : 2)) begin
        if (act == ACT_DECODE) begin
          i = 2'((n3 ? 2 : 1) - idx);
        end else begin
          i = 2'(idx);
        end
        if (r[i][qb]) begin
          r[0] = r[0] ^ p;
        end else begin
          t    = (r[0] ^ r[i]) & p;
          r[0] = r[0] ^ t;
          r[i] = r[i] ^ t;
        end
      end
    end
    return r;
  endfunction

  function automatic ax_t hic_deinterleave(key_t key, logic n3);
    ax_t r;
    r = '0;
    for (int unsigned b = 0; b < COORD_BITS; b++) begin
      if (n3) begin
        r[0][b] = key[3*b+2];
        r[1][b] = key[3*b+1];
        r[2][b] = key[3*b];
      end else begin
        r[0][b] = key[2*b+1];
        r[1][b] = key[2*b];
      end
    end
    return r;
  endfunction

  function automatic key_t hic_interleave(ax_t ax, logic n3);
    key_t k;
    k = '0;
    for (int unsigned b = 0; b < COORD_BITS; b++) begin
      if (n3) begin
        k[3*b+2] = ax[0][b];
        k[3*b+1] = ax[1][b];
        k[3*b]   = ax[2][b];
      end else begin
        k[2*b+1] = ax[0][b];
        k[2*b]   = ax[1][b];
      end
    end
    return k;
  endfunction

  // Gray decode ahead of the decode bit levels.
  function automatic ax_t hic_dec_prep(ax_t ax, logic n3);
    ax_t r;
    r = ax;
    if (n3) begin
      r[2] = ax[2] ^ ax[1];
      r[0] = ax[0] ^ (ax[2] >> 1);
    end else begin
      r[0] = ax[0] ^ (ax[1] >> 1);
    end
    r[1] = ax[1] ^ ax[0];
    return r;
  endfunction

  // Gray encode and top-bit parity fix after the encode bit levels.
  function automatic ax_t hic_enc_finish(ax_t ax, logic n3);
    ax_t    g;
    coord_t last;
    coord_t t;
    g    = ax;
    g[1] = ax[1] ^ g[0];
    if (n3) begin
      g[2] = ax[2] ^ g[1];
    end
    last = n3 ? g[2] : g[1];
    for (int unsigned k = 0; k < COORD_BITS; k++) begin
      t[k] = ^(last >> (k + 1));
    end
    g[0] = g[0] ^ t;
    g[1] = g[1] ^ t;
    if (n3) begin
      g[2] = g[2] ^ t;
    end
    return g;
  endfunction

endpackage

[hdl/hilbert_index_codec_top.sv]
// Hilbert curve index codec: coordinates to key and back, 2D or 3D.
// Depends on hic_pkg and hilbert_index_codec_top_macros.svh.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata x,y,z,key_in; tuser action
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata key_out,x,y,z
//   cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i dimensions
//
// One beat per cycle in each direction while m_axis_tready is held high; the pipeline has
// one entry stage, one stage per bit level (COORD_BITS - 1) and the exit stage.
// Each stage holds its beat while the next stage cannot take it, so bubbles close up.
// Reset empties the pipeline and sets dimensions to 2D.
`timescale 1ns / 1ps
`include "hilbert_index_codec_top_macros.svh"
module hilbert_index_codec_top
  import hic_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // coord_x [15:0], coord_y [31:16], coord_z [47:32], key_in [95:48]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action [0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // key_out [47:0], out_x [63:48], out_y [79:64], out_z [95:80]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [DimsW-1:0]    cfg_data_i
);

  localparam int unsigned NStage = COORD_BITS;

  logic [DimsW-1:0] dims_q;
  logic             n3;
  logic [NStage:0]  vld_q;
  logic [NStage:0]  vld_d;
  logic [NStage:0]  rdy;
  stage_t           st_q [NStage];
  stage_t           st_d [NStage];
  stage_t           in_st;
  stage_t           last_st;
  ax_t              in_ax;
  ax_t              fin_ax;
  key_t             key_q;
  key_t             key_d;
  coord_t           x_q, y_q, z_q;
  coord_t           x_d, y_d, z_d;
  action_e          out_act_q;
  logic             out_n3_q;

  assign cfg_ready_o = 1'b1;
  assign n3 = (dims_q == Dims3D);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DimsReset;
    end else if (cfg_valid_i) begin
      dims_q <= cfg_data_i;
    end
  end

  // ready chain: a stage takes a beat when it is empty or its content moves on
  assign rdy[NStage] = !vld_q[NStage] || m_axis_tready;
  for (genvar k = 0; k < NStage; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign s_axis_tready = rdy[0];

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int unsigned k = 1; k <= NStage; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // entry stage: unpack the coordinates, or de-interleave and Gray decode the key
  always_comb begin
    in_st.act = action_e'(s_axis_tuser);
    in_st.n3  = n3;
    if (in_st.act == ACT_DECODE) begin
      in_ax    = hic_deinterleave(s_axis_tdata[InDataW-1 -: KeyW], n3);
      in_st.ax = hic_dec_prep(in_ax, n3);
    end else begin
      in_ax[0] = s_axis_tdata[COORD_BITS-1:0];
      in_ax[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      in_ax[2] = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
      in_st.ax = in_ax;
    end
  end

  assign st_d[0] = in_st;

  for (genvar k = 1; k < NStage; k++) begin : g_lvl
    always_comb begin
      st_d[k] = st_q[k-1];
      if (st_q[k-1].act == ACT_DECODE) begin
        st_d[k].ax = hic_step(st_q[k-1].ax, st_q[k-1].act, st_q[k-1].n3,
                              CoordIdxW'(k));
      end else begin
        st_d[k].ax = hic_step(st_q[k-1].ax, st_q[k-1].act, st_q[k-1].n3,
                              CoordIdxW'(NStage - k));
      end
    end
  end

  for (genvar k = 0; k < NStage; k++) begin : g_stq
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // exit stage: Gray encode, parity fix and interleave, or place coordinates
  assign last_st = st_q[NStage-1];

  always_comb begin
    fin_ax = hic_enc_finish(last_st.ax, last_st.n3);
    key_d  = '0;
    x_d    = '0;
    y_d    = '0;
    z_d    = '0;
    if (last_st.act == ACT_DECODE) begin
      x_d = last_st.ax[0];
      y_d = last_st.ax[1];
      z_d = last_st.n3 ? last_st.ax[2] : '0;
    end else begin
      key_d = hic_interleave(fin_ax, last_st.n3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NStage]) begin
      key_q     <= key_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      out_act_q <= last_st.act;
      out_n3_q  <= last_st.n3;
    end
  end

  assign m_axis_tvalid = vld_q[NStage];
  assign m_axis_tdata  = {z_q, y_q, x_q, key_q};

  `HIC_ASSERT(a_full_when_blocked, clk_i, rst_ni, !s_axis_tready |-> (&vld_q), "input blocked with an empty stage")
  `HIC_ASSERT(a_entry_holds, clk_i, rst_ni, (vld_q[0] && !rdy[1]) |=> (vld_q[0] && $stable(st_q[0])), "entry stage lost a stalled beat")
  `HIC_ASSERT(a_dec_no_key, clk_i, rst_ni, (m_axis_tvalid && (out_act_q == ACT_DECODE)) |-> (key_q == '0), "decode result carries a key")
  `HIC_ASSERT(a_enc_no_coord, clk_i, rst_ni, (m_axis_tvalid && (out_act_q == ACT_ENCODE)) |-> ((x_q == '0) && (y_q == '0) && (z_q == '0)), "encode result carries coordinates")
  `HIC_ASSERT(a_2d_key_width, clk_i, rst_ni, (m_axis_tvalid && !out_n3_q) |-> (key_q[KeyW-1:2*COORD_BITS] == '0) && (z_q == '0), "2D result uses 3D bits")

endmodule
